@@ rtl/core/copa_pkg.sv @@
// Shared types, codes and sizes of the commandable output priority array.
package copa_pkg;

  localparam int NUM_OBJECTS    = 16;
  localparam int NUM_PRIORITIES = 16;
  localparam int OBJ_W          = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int LVL_IDX_W      = $clog2(NUM_PRIORITIES);

  localparam logic [7:0] LEVEL_NULL        = 8'd255;
  localparam logic [4:0] RESERVED_PRIORITY = 5'd6;
  localparam logic [7:0] MAX_PERCENT       = 8'd100;
  localparam logic [6:0] MAX_PERCENT_7     = 7'd100;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register addresses.
  localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_OBJECTS     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELINQUISH_DEFAULT = 2'd1;

  // Operation codes.
  localparam logic [2:0] FN_WRITE     = 3'd0;
  localparam logic [2:0] FN_RELINQ    = 3'd1;
  localparam logic [2:0] FN_READ_RES  = 3'd2;
  localparam logic [2:0] FN_READ_LVL  = 3'd3;
  localparam logic [2:0] FN_SET_OOS   = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_OBJ   = 2'd1;
  localparam logic [1:0] STAT_BAD_PRIO  = 2'd2;
  localparam logic [1:0] STAT_BAD_VALUE = 2'd3;

  // One memory row holds every priority level of one object.
  typedef logic [NUM_PRIORITIES-1:0][7:0] row_t;

endpackage

@@ rtl/core/copa_if.sv @@
// Channel interfaces of the commandable output priority array.
interface copa_op_if;
  logic       valid;
  logic       ready;
  logic [2:0]  func;
  logic [15:0] object_num;
  logic [4:0]  prio_level;
  logic [7:0]  level_value;
  logic        oos_value;

  modport source (output valid, func, object_num, prio_level, level_value, oos_value,
                  input ready);
  modport sink   (input valid, func, object_num, prio_level, level_value, oos_value,
                  output ready);
endinterface

interface copa_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status_code;
  logic [6:0] resolved_value;
  logic       level_is_null;
  logic [4:0] active_priority;
  logic       oos_flag;

  modport source (output valid, status_code, resolved_value, level_is_null,
                  active_priority, oos_flag, input ready);
  modport sink   (input valid, status_code, resolved_value, level_is_null,
                  active_priority, oos_flag, output ready);
endinterface

interface copa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [copa_pkg::CFG_ADDR_W-1:0] addr;
  logic [copa_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

@@ rtl/core/commandable_output_priority_array.sv @@
// Top level of the commandable output priority array.
//
// Operations arrive on in_op, one word per command: write or relinquish a
// priority level, read the resolved value, read one level, or set the
// out-of-service flag. Each accepted word gives exactly one response word on
// out_rsp, in order. cfg_wr writes the active object count and the relinquish
// default, always ready; the user must write it only while idle (not enforced).
//
// The levels of one object sit in one row of a synchronous memory. The row is
// read at the accept edge; in the execute state, once the output register is
// free, the level is modified, the row written back, the 16-level priority
// encode done and the response registered. A new word is not taken until the
// previous one has left the execute state.
//
// A response held by a stalled receiver stays in the output register; the
// next word is still accepted and waits in the execute state until the
// output register frees. Reset clears the row valid bits (every level reads
// as null), the out-of-service flags, the state, output-valid and relinquish
// default registers, and sets the active object count to 16; no clearing pass.
module commandable_output_priority_array (
  input  logic        clk,
  input  logic        rst_n,
  copa_op_if.sink     in_op,
  copa_rsp_if.source  out_rsp,
  copa_cfg_if.sink    cfg_wr
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [4:0] active_objects_r;
  logic [6:0] relinq_dflt_r;

  // Captured operation.
  logic [2:0]                    func_r;
  logic [copa_pkg::OBJ_W-1:0]    obj_r;
  logic                          obj_ok_r;
  logic [4:0]                    prio_r;
  logic [7:0]                    val_r;
  logic                          oos_in_r;

  // Row memory, its valid bits and the out-of-service flags.
  copa_pkg::row_t                mem [copa_pkg::NUM_OBJECTS];
  copa_pkg::row_t                rdata_r;
  logic                          rvld_r;
  logic [copa_pkg::NUM_OBJECTS-1:0] row_vld_r;
  logic [copa_pkg::NUM_OBJECTS-1:0] oos_flags_r;

  // Response register.
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [6:0] out_value_r;
  logic       out_null_r;
  logic [4:0] out_prio_r;
  logic       out_oos_r;

  logic                          accept;
  logic                          finish;
  logic [copa_pkg::OBJ_W-1:0]    in_obj;
  logic                          in_obj_ok;
  copa_pkg::row_t                cur_row;
  copa_pkg::row_t                new_row;
  logic                          wr_en;
  logic [copa_pkg::LVL_IDX_W-1:0] pidx;
  logic                          prio_ok;
  logic [6:0]                    dflt;
  logic [6:0]                    res_val;
  logic [4:0]                    res_prio;
  logic                          oos_set;
  logic [1:0]                    st_nxt;
  logic [6:0]                    val_nxt;
  logic                          null_nxt;
  logic [4:0]                    prio_nxt;
  logic                          oos_nxt;

  assign in_op.ready  = (state_r == S_IDLE);
  assign accept       = in_op.valid && in_op.ready;
  assign finish       = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);
  assign cfg_wr.ready = 1'b1;

  assign in_obj    = in_op.object_num[copa_pkg::OBJ_W-1:0];
  assign in_obj_ok = (in_op.object_num < 16'(active_objects_r)) &&
                     (in_op.object_num < 16'(copa_pkg::NUM_OBJECTS));

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = finish ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      active_objects_r <= 5'd16;
      relinq_dflt_r    <= 7'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        if (cfg_wr.addr == copa_pkg::CFG_ACTIVE_OBJECTS) begin
          active_objects_r <= cfg_wr.wdata[4:0];
        end else if (cfg_wr.addr == copa_pkg::CFG_RELINQUISH_DEFAULT) begin
          relinq_dflt_r <= cfg_wr.wdata[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_op.func;
      obj_r    <= in_obj;
      obj_ok_r <= in_obj_ok;
      prio_r   <= in_op.prio_level;
      val_r    <= in_op.level_value;
      oos_in_r <= in_op.oos_value;
    end
  end

  // The row is read at the accept edge and held until the next accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= mem[in_obj];
    end
    if (wr_en) begin
      mem[obj_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      oos_flags_r <= '0;
      rvld_r      <= 1'b0;
    end else begin
      if (accept) begin
        rvld_r <= row_vld_r[in_obj];
      end
      if (wr_en) begin
        row_vld_r[obj_r] <= 1'b1;
      end
      if (oos_set) begin
        oos_flags_r[obj_r] <= oos_in_r;
      end
    end
  end

  // Execute: modify the level, resolve the row and form the response.
  always_comb begin
    cur_row  = rvld_r ? rdata_r : {copa_pkg::NUM_PRIORITIES{copa_pkg::LEVEL_NULL}};
    new_row  = cur_row;
    pidx     = copa_pkg::LVL_IDX_W'(prio_r - 5'd1);
    prio_ok  = (prio_r >= 5'd1) && (prio_r <= 5'(copa_pkg::NUM_PRIORITIES));
    dflt     = (relinq_dflt_r > copa_pkg::MAX_PERCENT_7) ? copa_pkg::MAX_PERCENT_7
                                                         : relinq_dflt_r;
    wr_en    = 1'b0;
    oos_set  = 1'b0;
    st_nxt   = copa_pkg::STAT_OK;
    val_nxt  = 7'd0;
    null_nxt = 1'b0;
    prio_nxt = 5'd0;

    unique case (func_r) inside
      copa_pkg::FN_WRITE, copa_pkg::FN_RELINQ: begin
        if (!prio_ok || prio_r == copa_pkg::RESERVED_PRIORITY) begin
          st_nxt = copa_pkg::STAT_BAD_PRIO;
        end else if (func_r == copa_pkg::FN_WRITE && val_r > copa_pkg::MAX_PERCENT) begin
          st_nxt = copa_pkg::STAT_BAD_VALUE;
        end else begin
          new_row[pidx] = (func_r == copa_pkg::FN_WRITE) ? val_r : copa_pkg::LEVEL_NULL;
          wr_en         = finish && obj_ok_r;
        end
      end
      copa_pkg::FN_SET_OOS: begin
        oos_set = finish && obj_ok_r;
      end
      default: begin
      end
    endcase

    // Lowest-numbered non-null level wins.
    res_val  = dflt;
    res_prio = 5'd0;
    for (int i = copa_pkg::NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (new_row[i] != copa_pkg::LEVEL_NULL) begin
        res_val  = new_row[i][6:0];
        res_prio = 5'(i + 1);
      end
    end

    if (func_r == copa_pkg::FN_READ_LVL) begin
      if (!prio_ok) begin
        st_nxt = copa_pkg::STAT_BAD_PRIO;
      end else if (cur_row[pidx] == copa_pkg::LEVEL_NULL) begin
        null_nxt = 1'b1;
      end else begin
        val_nxt = cur_row[pidx][6:0];
      end
    end else begin
      val_nxt  = res_val;
      prio_nxt = res_prio;
    end

    oos_nxt = (func_r == copa_pkg::FN_SET_OOS) ? oos_in_r : oos_flags_r[obj_r];

    if (!obj_ok_r) begin
      st_nxt   = copa_pkg::STAT_BAD_OBJ;
      val_nxt  = 7'd0;
      null_nxt = 1'b0;
      prio_nxt = 5'd0;
      oos_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= st_nxt;
      out_value_r  <= val_nxt;
      out_null_r   <= null_nxt;
      out_prio_r   <= prio_nxt;
      out_oos_r    <= oos_nxt;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status_code     = out_status_r;
  assign out_rsp.resolved_value  = out_value_r;
  assign out_rsp.level_is_null   = out_null_r;
  assign out_rsp.active_priority = out_prio_r;
  assign out_rsp.oos_flag        = out_oos_r;

endmodule
